// ===== rtl/terminal_text_stream_decoder_unit_defines.svh =====
// Assertion macros shared by the terminal text stream decoder RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef TERMINAL_TEXT_STREAM_DECODER_UNIT_DEFINES_SVH
`define TERMINAL_TEXT_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttsd_pkg.sv =====
// Shared types, constants and lookup functions of the terminal text stream decoder.
// No dependencies; imported by the controller, the datapath and the top level.
package ttsd_pkg;

  localparam int unsigned MAX_SGR_PARAMS = 8;
  localparam int unsigned SGR_IDX_W = (MAX_SGR_PARAMS > 1) ? $clog2(MAX_SGR_PARAMS) : 1;
  localparam int unsigned SGR_VAL_W = 7;
  localparam logic [SGR_VAL_W-1:0] SGR_CAP = 7'd127;

  localparam int unsigned CP_W = 21;
  localparam int unsigned POS_W = 12;
  localparam int unsigned RGB_W = 24;
  localparam int unsigned CELL_W = 6;

  localparam logic [RGB_W-1:0] FG_DEFAULT = 24'hAAAAAA;
  localparam logic [RGB_W-1:0] BG_DEFAULT = 24'h000000;
  localparam logic [RGB_W-1:0] BOLD_MASK  = 24'h555555;

  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_LF   = 21'h00000A;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_M     = 8'h6D;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [1:0] CFG_CELL_W   = 2'd2;
  localparam logic [1:0] CFG_CELL_H   = 2'd3;

  localparam logic EV_DRAW = 1'b0;
  localparam logic EV_LF   = 1'b1;

  typedef enum logic [2:0] {
    MODE_TEXT = 3'b001,
    MODE_ESC  = 3'b010,
    MODE_CSI  = 3'b100
  } ttsd_mode_e;

  typedef struct packed {
    logic accept;
    logic emit_go;
    logic apply_step;
  } ttsd_cmd_t;

  typedef struct packed {
    logic emit;
    logic apply;
    logic apply_last;
  } ttsd_stat_t;

  function automatic logic [RGB_W-1:0] palette(input logic [3:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      4'd0:  c = 24'h000000;
      4'd1:  c = 24'hAA0000;
      4'd2:  c = 24'h00AA00;
      4'd3:  c = 24'hAA5500;
      4'd4:  c = 24'h0000AA;
      4'd5:  c = 24'hAA00AA;
      4'd6:  c = 24'h00AAAA;
      4'd7:  c = 24'hAAAAAA;
      4'd8:  c = 24'h555555;
      4'd9:  c = 24'hFF5555;
      4'd10: c = 24'h55FF55;
      4'd11: c = 24'hFFFF55;
      4'd12: c = 24'h5555FF;
      4'd13: c = 24'hFF55FF;
      4'd14: c = 24'h55FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic is_wide(input logic [CP_W-1:0] c);
    return (c >= 21'h1100 && c <= 21'h115F) || (c >= 21'h2E80 && c <= 21'h303E) ||
           (c >= 21'h3040 && c <= 21'h33FF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
           (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'hAC00 && c <= 21'hD7AF) ||
           (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'hFE10 && c <= 21'hFE6F) ||
           (c >= 21'hFF01 && c <= 21'hFF60) || (c >= 21'hFFE0 && c <= 21'hFFE6);
  endfunction

endpackage

// ===== rtl/terminal_text_stream_decoder_unit.sv =====
// Top level of the terminal text stream decoder: UTF-8, SGR colors and cursor events.
// Depends on ttsd_pkg, ttsd_ctrl and ttsd_dp.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid_i/in_ready_o   byte_in_i
//   out      from block out_valid_o/out_ready_i event_kind_o .. scroll_up_o
//   cfg      to block   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A byte that gives no event is done once accepted. A byte that gives an event is then
// emitted: the cursor unit updates and the output register loads, waiting while the
// output register still holds an untaken word. After the 'm' terminator the color logic
// walks the parameter store one entry a cycle. Reset restores control, parser, colors,
// cursor and configuration; the SGR store, pending event and output word are not reset.
module terminal_text_stream_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [11:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  byte_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        event_kind_o,
  output logic [ttsd_pkg::CP_W-1:0]   code_point_o,
  output logic [ttsd_pkg::POS_W-1:0]  pos_x_o,
  output logic [ttsd_pkg::POS_W-1:0]  pos_y_o,
  output logic [ttsd_pkg::RGB_W-1:0]  fg_rgb_o,
  output logic [ttsd_pkg::RGB_W-1:0]  bg_rgb_o,
  output logic                        double_width_o,
  output logic                        scroll_up_o
);
  import ttsd_pkg::*;

  ttsd_cmd_t  cmd;
  ttsd_stat_t stat;

  ttsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ttsd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .byte_in_i      (byte_in_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .event_kind_o   (event_kind_o),
    .code_point_o   (code_point_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .fg_rgb_o       (fg_rgb_o),
    .bg_rgb_o       (bg_rgb_o),
    .double_width_o (double_width_o),
    .scroll_up_o    (scroll_up_o)
  );

endmodule

// ===== rtl/ttsd_ctrl.sv =====
// Sequencer of the terminal text stream decoder: accept, emit and SGR apply phases.
// Depends on ttsd_pkg and the assertion macro header.
`include "terminal_text_stream_decoder_unit_defines.svh"

module ttsd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ttsd_pkg::ttsd_stat_t stat_i,
  output ttsd_pkg::ttsd_cmd_t  cmd_o
);
  import ttsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EMIT  = 3'b010,
    S_APPLY = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.accept     = in_valid_i && (state_q == S_IDLE);
    cmd_o.emit_go    = (state_q == S_EMIT) && slot_free;
    cmd_o.apply_step = (state_q == S_APPLY);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && stat_i.emit) begin
          state_d = S_EMIT;
        end else if (cmd_o.accept && stat_i.apply) begin
          state_d = S_APPLY;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      S_APPLY: begin
        if (stat_i.apply_last) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // Output word stays until taken; a new word overwrites only a free slot
  always_comb begin
    if (cmd_o.emit_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TTSD_ASSERT_NXT(a_emit_follows, clk_i, rst_ni, cmd_o.accept && stat_i.emit,
                   state_q == S_EMIT, "event byte did not enter emit phase")
  `TTSD_ASSERT_NXT(a_emit_delivers, clk_i, rst_ni, cmd_o.emit_go,
                   out_valid_o && state_q == S_IDLE, "emit phase did not load a word")
  `TTSD_ASSERT_NXT(a_apply_ends, clk_i, rst_ni, cmd_o.apply_step && stat_i.apply_last,
                   state_q == S_IDLE, "SGR walk did not stop at last parameter")

endmodule

// ===== rtl/ttsd_dp.sv =====
// Datapath of the terminal text stream decoder: parser state, SGR store, colors, cursor.
// Depends on ttsd_pkg; driven by commands from ttsd_ctrl.
module ttsd_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [11:0]                 cfg_wdata_i,
  input  logic [7:0]                  byte_in_i,
  input  ttsd_pkg::ttsd_cmd_t         cmd_i,
  output ttsd_pkg::ttsd_stat_t        stat_o,
  output logic                        event_kind_o,
  output logic [ttsd_pkg::CP_W-1:0]   code_point_o,
  output logic [ttsd_pkg::POS_W-1:0]  pos_x_o,
  output logic [ttsd_pkg::POS_W-1:0]  pos_y_o,
  output logic [ttsd_pkg::RGB_W-1:0]  fg_rgb_o,
  output logic [ttsd_pkg::RGB_W-1:0]  bg_rgb_o,
  output logic                        double_width_o,
  output logic                        scroll_up_o
);
  import ttsd_pkg::*;

  localparam logic [SGR_IDX_W:0] SGR_MAX_C = (SGR_IDX_W + 1)'(MAX_SGR_PARAMS);

  // Configuration
  logic [POS_W-1:0]  scr_w_q, scr_h_q;
  logic [CELL_W-1:0] cell_w_q, cell_h_q;

  // Parser
  ttsd_mode_e        mode_q, mode_d;
  logic [1:0]        rem_q, rem_d;
  logic [CP_W-1:0]   acc_q, acc_d;
  logic [SGR_IDX_W-1:0] idx_q, idx_d;
  logic [SGR_IDX_W-1:0] apply_j_q;
  logic [SGR_VAL_W-1:0] sgr_q [MAX_SGR_PARAMS];

  logic                 sgr_we;
  logic [SGR_IDX_W-1:0] sgr_wa, sgr_ra;
  logic [SGR_VAL_W-1:0] sgr_wd, sgr_rd;
  logic [10:0]          digit_v;
  logic                 tb_en, cr_hit, emit, apply;

  // Pending event
  logic              ev_kind_q, ev_kind_d;
  logic [CP_W-1:0]   ev_cp_q, ev_cp_d;
  logic              ev_wide_q;

  // Colors and cursor
  logic [RGB_W-1:0]  fg_q, fg_d, bg_q, bg_d;
  logic [POS_W-1:0]  cur_x_q, cur_y_q, new_x, new_y, opos_x, opos_y;
  logic [CELL_W-1:0] adv;
  logic [POS_W:0]    x1, y1;
  logic [POS_W+1:0]  x_sum, y_sum;
  logic              wrap, scr, oscroll;
  logic [6:0]        p_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= 12'd640;
      scr_h_q  <= 12'd480;
      cell_w_q <= 6'd16;
      cell_h_q <= 6'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_W: scr_w_q  <= cfg_wdata_i;
        CFG_SCREEN_H: scr_h_q  <= cfg_wdata_i;
        CFG_CELL_W:   cell_w_q <= cfg_wdata_i[CELL_W-1:0];
        CFG_CELL_H:   cell_h_q <= cfg_wdata_i[CELL_W-1:0];
      endcase
    end
  end

  assign sgr_ra = cmd_i.apply_step ? apply_j_q : idx_q;
  assign sgr_rd = sgr_q[sgr_ra];
  assign digit_v = {1'b0, sgr_rd, 3'b000} + {3'b000, sgr_rd, 1'b0}
                 + {7'd0, byte_in_i[3:0] - CH_ZERO[3:0]};

  always_comb begin
    mode_d    = mode_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    idx_d     = idx_q;
    sgr_we    = 1'b0;
    sgr_wa    = idx_q;
    sgr_wd    = '0;
    tb_en     = 1'b0;
    cr_hit    = 1'b0;
    emit      = 1'b0;
    apply     = 1'b0;
    ev_kind_d = EV_DRAW;
    ev_cp_d   = CP_REPL;
    if (rem_q != 2'd0) begin
      // Any byte counts as continuation while a sequence is pending
      acc_d = {acc_q[CP_W-7:0], byte_in_i[5:0]};
      rem_d = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        emit    = 1'b1;
        ev_cp_d = acc_d;
      end
    end else begin
      unique case (mode_q)
        MODE_TEXT: tb_en = 1'b1;
        MODE_ESC: begin
          if (byte_in_i == CH_LBRK) begin
            mode_d = MODE_CSI;
            idx_d  = '0;
            sgr_we = 1'b1;
            sgr_wa = '0;
          end else begin
            mode_d = MODE_TEXT;
            tb_en  = 1'b1;
          end
        end
        MODE_CSI: begin
          if (byte_in_i >= CH_ZERO && byte_in_i <= CH_NINE) begin
            sgr_we = 1'b1;
            sgr_wd = (digit_v > {4'd0, SGR_CAP}) ? SGR_CAP : digit_v[SGR_VAL_W-1:0];
          end else if (byte_in_i == CH_SEMI) begin
            // Extra separators past the last slot are dropped
            if (({1'b0, idx_q} + (SGR_IDX_W + 1)'(1)) < SGR_MAX_C) begin
              idx_d  = idx_q + SGR_IDX_W'(1);
              sgr_we = 1'b1;
              sgr_wa = idx_d;
            end
          end else begin
            apply  = (byte_in_i == CH_M);
            mode_d = MODE_TEXT;
          end
        end
      endcase
      if (tb_en) begin
        if (byte_in_i == CH_ESC) begin
          mode_d = MODE_ESC;
        end else if (byte_in_i == CH_LF) begin
          emit      = 1'b1;
          ev_kind_d = EV_LF;
          ev_cp_d   = CP_LF;
        end else if (byte_in_i == CH_CR) begin
          cr_hit = 1'b1;
        end else if (byte_in_i >= CH_SPACE && byte_in_i < 8'h80) begin
          emit    = 1'b1;
          ev_cp_d = {13'd0, byte_in_i};
        end else if (byte_in_i >= 8'h80 && byte_in_i < 8'hC0) begin
          emit = 1'b1;
        end else if (byte_in_i >= 8'hC0 && byte_in_i < 8'hE0) begin
          acc_d = {16'd0, byte_in_i[4:0]};
          rem_d = 2'd1;
        end else if (byte_in_i >= 8'hE0 && byte_in_i < 8'hF0) begin
          acc_d = {17'd0, byte_in_i[3:0]};
          rem_d = 2'd2;
        end else if (byte_in_i >= 8'hF0) begin
          acc_d = {18'd0, byte_in_i[2:0]};
          rem_d = 2'd3;
        end
      end
    end
  end

  always_comb begin
    stat_o.emit       = emit;
    stat_o.apply      = apply;
    stat_o.apply_last = (apply_j_q == idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_TEXT;
      rem_q     <= 2'd0;
      acc_q     <= '0;
      idx_q     <= '0;
      apply_j_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        mode_q <= mode_d;
        rem_q  <= rem_d;
        acc_q  <= acc_d;
        idx_q  <= idx_d;
      end
      if (cmd_i.accept && apply) begin
        apply_j_q <= '0;
      end else if (cmd_i.apply_step) begin
        apply_j_q <= apply_j_q + SGR_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sgr_we) begin
      sgr_q[sgr_wa] <= sgr_wd;
    end
    if (cmd_i.accept && emit) begin
      ev_kind_q <= ev_kind_d;
      ev_cp_q   <= ev_cp_d;
      ev_wide_q <= is_wide(ev_cp_d);
    end
  end

  // One SGR parameter per step
  always_comb begin
    fg_d  = fg_q;
    bg_d  = bg_q;
    p_off = '0;
    if (sgr_rd == 7'd0) begin
      fg_d = FG_DEFAULT;
      bg_d = BG_DEFAULT;
    end else if (sgr_rd == 7'd1) begin
      fg_d = fg_q | BOLD_MASK;
    end else if (sgr_rd >= 7'd30 && sgr_rd <= 7'd37) begin
      p_off = sgr_rd - 7'd30;
      fg_d  = palette({1'b0, p_off[2:0]});
    end else if (sgr_rd >= 7'd90 && sgr_rd <= 7'd97) begin
      p_off = sgr_rd - 7'd90;
      fg_d  = palette({1'b1, p_off[2:0]});
    end else if (sgr_rd == 7'd39) begin
      fg_d = FG_DEFAULT;
    end else if (sgr_rd >= 7'd40 && sgr_rd <= 7'd47) begin
      p_off = sgr_rd - 7'd40;
      bg_d  = palette({1'b0, p_off[2:0]});
    end else if (sgr_rd == 7'd49) begin
      bg_d = BG_DEFAULT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_DEFAULT;
      bg_q <= BG_DEFAULT;
    end else if (cmd_i.apply_step) begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  // Cursor advance, wrap and line feed
  always_comb begin
    adv   = ev_wide_q ? cell_w_q : (cell_w_q >> 1);
    x1    = {1'b0, cur_x_q} + {7'd0, adv};
    x_sum = {1'b0, x1} + {8'd0, cell_w_q};
    wrap  = x_sum > {2'b00, scr_w_q};
    y1    = {1'b0, cur_y_q} + {7'd0, cell_h_q};
    y_sum = {1'b0, y1} + {8'd0, cell_h_q};
    scr   = y_sum > {2'b00, scr_h_q};
    if (ev_kind_q == EV_LF) begin
      new_x   = '0;
      new_y   = scr ? cur_y_q : y1[POS_W-1:0];
      opos_x  = new_x;
      opos_y  = new_y;
      oscroll = scr;
    end else begin
      new_x   = wrap ? '0 : x1[POS_W-1:0];
      new_y   = (wrap && !scr) ? y1[POS_W-1:0] : cur_y_q;
      opos_x  = cur_x_q;
      opos_y  = cur_y_q;
      oscroll = wrap && scr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else if (cmd_i.emit_go) begin
      cur_x_q <= new_x;
      cur_y_q <= new_y;
    end else if (cmd_i.accept && cr_hit) begin
      cur_x_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_go) begin
      event_kind_o   <= ev_kind_q;
      code_point_o   <= ev_cp_q;
      pos_x_o        <= opos_x;
      pos_y_o        <= opos_y;
      fg_rgb_o       <= fg_q;
      bg_rgb_o       <= bg_q;
      double_width_o <= (ev_kind_q == EV_DRAW) && ev_wide_q;
      scroll_up_o    <= oscroll;
    end
  end

endmodule

// ===== dv/terminal_text_stream_decoder_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for terminal_text_stream_decoder_unit: directed and random bytes
// in, glyph and line feed events out, checked against an in-bench event predictor.
// Depends on ttsd_pkg and the RTL of the decoder.
module terminal_text_stream_decoder_unit_test;
  import ttsd_pkg::*;

  localparam int unsigned LIMIT_CYCLES     = 200000;
  localparam int unsigned SETTLE_CYCLES    = 24;
  localparam int unsigned RANDOM_PER_PHASE = 72;
  localparam int unsigned NUM_PHASES       = 6;
  localparam int unsigned MAX_GAP          = 16;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS      = 40;

  // SGR parameter codes
  localparam int unsigned SGR_RESET       = 0;
  localparam int unsigned SGR_BOLD        = 1;
  localparam int unsigned SGR_FG_FIRST    = 30;
  localparam int unsigned SGR_FG_LAST     = 37;
  localparam int unsigned SGR_FG_DEFAULT  = 39;
  localparam int unsigned SGR_BG_FIRST    = 40;
  localparam int unsigned SGR_BG_LAST     = 47;
  localparam int unsigned SGR_BG_DEFAULT  = 49;
  localparam int unsigned SGR_FGB_FIRST   = 90;
  localparam int unsigned SGR_FGB_LAST    = 97;

  localparam int unsigned WIDE_LO [10] = '{'h1100, 'h2E80, 'h3040, 'h3400, 'h4E00,
                                           'hAC00, 'hF900, 'hFE10, 'hFF01, 'hFFE0};
  localparam int unsigned WIDE_HI [10] = '{'h115F, 'h303E, 'h33FF, 'h4DBF, 'h9FFF,
                                           'hD7AF, 'hFAFF, 'hFE6F, 'hFF60, 'hFFE6};

  // Screen and cell settings per phase: defaults, maxima, minima, zeros, oversized, odd
  localparam logic [11:0] PH_SCREEN_W [NUM_PHASES] = '{640, 4095, 1, 0, 200, 320};
  localparam logic [11:0] PH_SCREEN_H [NUM_PHASES] = '{480, 4095, 1, 0, 100, 64};
  localparam logic [11:0] PH_CELL_W   [NUM_PHASES] = '{16, 32, 1, 0, 63, 9};
  localparam logic [11:0] PH_CELL_H   [NUM_PHASES] = '{16, 32, 1, 0, 63, 5};

  typedef struct {
    logic             kind;
    logic [CP_W-1:0]  cp;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [RGB_W-1:0] fg;
    logic [RGB_W-1:0] bg;
    logic             wide;
    logic             scroll;
  } term_event_t;

  class term_event_board;
    logic [POS_W-1:0]     screen_w, screen_h;
    logic [CELL_W-1:0]    cell_w, cell_h;
    ttsd_mode_e           mode;
    int unsigned          utf_left;
    logic [CP_W-1:0]      utf_acc;
    logic [SGR_VAL_W-1:0] sgr_val [MAX_SGR_PARAMS];
    int unsigned          sgr_idx;
    logic [RGB_W-1:0]     fore, back;
    logic [POS_W-1:0]     cur_x, cur_y;
    term_event_t          expected_events[$];
    int unsigned          errors;

    function new();
      screen_w = 12'd640;
      screen_h = 12'd480;
      cell_w   = 6'd16;
      cell_h   = 6'd16;
      mode     = MODE_TEXT;
      utf_left = 0;
      utf_acc  = '0;
      sgr_idx  = 0;
      fore     = FG_DEFAULT;
      back     = BG_DEFAULT;
      cur_x    = '0;
      cur_y    = '0;
      errors   = 0;
      foreach (sgr_val[i]) sgr_val[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] val);
      case (idx)
        CFG_SCREEN_W: screen_w = val;
        CFG_SCREEN_H: screen_h = val;
        CFG_CELL_W:   cell_w = val[CELL_W-1:0];
        default:      cell_h = val[CELL_W-1:0];
      endcase
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction

    function bit cjk_wide(logic [CP_W-1:0] cp);
      foreach (WIDE_LO[i])
        if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) return 1'b1;
      return 1'b0;
    endfunction

    // 16-color palette: bit 0 red, bit 1 green, bit 2 blue, bit 3 bright; brown is special
    function logic [RGB_W-1:0] ansi_color(int unsigned i);
      logic [7:0] on, off, r, g, b;
      on  = (i >= 8) ? 8'hFF : 8'hAA;
      off = (i >= 8) ? 8'h55 : 8'h00;
      r = i[0] ? on : off;
      g = i[1] ? on : off;
      b = i[2] ? on : off;
      if (i == 3) g = 8'h55;
      return {r, g, b};
    endfunction

    // Return 1 when the move to the next line scrolls the screen
    function bit next_line();
      int unsigned y;
      bit scrolled;
      scrolled = 1'b0;
      cur_x = '0;
      y = cur_y + cell_h;
      if (y + cell_h > screen_h) begin
        y = y - cell_h;
        scrolled = 1'b1;
      end
      cur_y = y[POS_W-1:0];
      return scrolled;
    endfunction

    function void push(logic kind, logic [CP_W-1:0] cp, logic [POS_W-1:0] x,
                       logic [POS_W-1:0] y, logic wide, logic scroll);
      term_event_t ev;
      ev.kind   = kind;
      ev.cp     = cp;
      ev.x      = x;
      ev.y      = y;
      ev.fg     = fore;
      ev.bg     = back;
      ev.wide   = wide;
      ev.scroll = scroll;
      expected_events.push_back(ev);
    endfunction

    function void put_glyph(logic [CP_W-1:0] cp);
      logic [POS_W-1:0] x0, y0;
      int unsigned nx;
      bit wide, scroll;
      x0 = cur_x;
      y0 = cur_y;
      wide = cjk_wide(cp);
      scroll = 1'b0;
      nx = cur_x + (wide ? cell_w : (cell_w >> 1));
      if (nx + cell_w > screen_w) scroll = next_line();
      else cur_x = nx[POS_W-1:0];
      push(EV_DRAW, cp, x0, y0, wide, scroll);
    endfunction

    function void apply_colors();
      int unsigned p;
      for (int unsigned j = 0; j <= sgr_idx && j < MAX_SGR_PARAMS; j++) begin
        p = sgr_val[j];
        if (p == SGR_RESET) begin
          fore = FG_DEFAULT;
          back = BG_DEFAULT;
        end else if (p == SGR_BOLD) fore = fore | BOLD_MASK;
        else if (p >= SGR_FG_FIRST && p <= SGR_FG_LAST) fore = ansi_color(p - SGR_FG_FIRST);
        else if (p >= SGR_FGB_FIRST && p <= SGR_FGB_LAST)
          fore = ansi_color(p - SGR_FGB_FIRST + 8);
        else if (p == SGR_FG_DEFAULT) fore = FG_DEFAULT;
        else if (p >= SGR_BG_FIRST && p <= SGR_BG_LAST) back = ansi_color(p - SGR_BG_FIRST);
        else if (p == SGR_BG_DEFAULT) back = BG_DEFAULT;
      end
    endfunction

    function void take_text_byte(logic [7:0] b);
      bit scroll;
      if (b == CH_ESC) mode = MODE_ESC;
      else if (b == CH_LF) begin
        scroll = next_line();
        push(EV_LF, CP_LF, cur_x, cur_y, 1'b0, scroll);
      end else if (b == CH_CR) cur_x = '0;
      else if (b < CH_SPACE) begin
        // drop other control bytes
      end else if (b < 8'h80) put_glyph(CP_W'(b));
      else if (b < 8'hC0) put_glyph(CP_REPL);
      else if (b < 8'hE0) begin
        utf_acc = CP_W'(b[4:0]);
        utf_left = 1;
      end else if (b < 8'hF0) begin
        utf_acc = CP_W'(b[3:0]);
        utf_left = 2;
      end else begin
        utf_acc = CP_W'(b[2:0]);
        utf_left = 3;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned k, v;
      if (utf_left > 0) begin
        // any byte counts as a continuation here
        utf_acc = {utf_acc[CP_W-7:0], b[5:0]};
        utf_left--;
        if (utf_left == 0) put_glyph(utf_acc);
        return;
      end
      case (mode)
        MODE_ESC: begin
          if (b == CH_LBRK) begin
            mode = MODE_CSI;
            sgr_idx = 0;
            sgr_val[0] = '0;
          end else begin
            mode = MODE_TEXT;
            take_text_byte(b);
          end
        end
        MODE_CSI: begin
          k = (sgr_idx < MAX_SGR_PARAMS) ? sgr_idx : MAX_SGR_PARAMS - 1;
          if (b >= CH_ZERO && b <= CH_NINE) begin
            v = sgr_val[k] * 10 + (b - CH_ZERO);
            sgr_val[k] = (v > SGR_CAP) ? SGR_CAP : v[SGR_VAL_W-1:0];
          end else if (b == CH_SEMI) begin
            if (k + 1 < MAX_SGR_PARAMS) begin
              sgr_idx = k + 1;
              sgr_val[sgr_idx] = '0;
            end
          end else begin
            if (b == CH_M) apply_colors();
            mode = MODE_TEXT;
          end
        end
        default: take_text_byte(b);
      endcase
    endfunction

    function void compare_field(string name, logic [RGB_W-1:0] want, logic [RGB_W-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_event(term_event_t got);
      term_event_t want;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected event: expected none, actual code point %h",
                   $time, got.cp);
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind", want.kind, got.kind);
      compare_field("code_point", want.cp, got.cp);
      compare_field("pos_x", want.x, got.x);
      compare_field("pos_y", want.y, got.y);
      compare_field("fg_rgb", want.fg, got.fg);
      compare_field("bg_rgb", want.bg, got.bg);
      compare_field("double_width", want.wide, got.wide);
      compare_field("scroll_up", want.scroll, got.scroll);
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_idx_i   = CFG_SCREEN_W;
  logic [11:0]       cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        byte_in_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              event_kind_o;
  logic [CP_W-1:0]   code_point_o;
  logic [POS_W-1:0]  pos_x_o;
  logic [POS_W-1:0]  pos_y_o;
  logic [RGB_W-1:0]  fg_rgb_o;
  logic [RGB_W-1:0]  bg_rgb_o;
  logic              double_width_o;
  logic              scroll_up_o;

  term_event_board board;
  int unsigned     bytes_sent   = 0;
  int unsigned     cycle_count  = 0;
  bit              sender_calm  = 1'b0;

  terminal_text_stream_decoder_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_in_i      (byte_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .code_point_o   (code_point_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .fg_rgb_o       (fg_rgb_o),
    .bg_rgb_o       (bg_rgb_o),
    .double_width_o (double_width_o),
    .scroll_up_o    (scroll_up_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  // Hold input off until every event is out and the color walk has settled
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic int unsigned pick_sgr_value();
    case ($urandom_range(0, 7))
      0:       return SGR_RESET;
      1:       return SGR_BOLD;
      2:       return $urandom_range(SGR_FG_FIRST, SGR_FG_LAST);
      3:       return $urandom_range(SGR_BG_FIRST, SGR_BG_LAST);
      4:       return $urandom_range(SGR_FGB_FIRST, SGR_FGB_LAST);
      5:       return $urandom_range(0, 1) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
      6:       return $urandom_range(0, 999);
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  task automatic send_number(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
  endtask

  // ESC [ params terminator; sometimes too many, empty or oversized params
  task automatic send_color_seq();
    int unsigned n;
    logic [7:0] term;
    n = $urandom_range(0, 10);
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    for (int unsigned i = 0; i < n; i++) begin
      if (i > 0) send_byte(CH_SEMI);
      if ($urandom_range(0, 7) != 0) send_number(pick_sgr_value());
    end
    term = CH_M;
    if ($urandom_range(0, 3) == 0) begin
      do term = 8'($urandom_range(0, 255));
      while ((term >= CH_ZERO && term <= CH_NINE) || term == CH_SEMI);
    end
    send_byte(term);
  endtask

  task automatic send_random_chunk();
    int unsigned n;
    logic [15:0] cp;
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7F)));
      end
      2: begin
        case ($urandom_range(0, 3))
          0, 1:    send_byte(CH_LF);
          2:       send_byte(CH_CR);
          default: send_byte(8'($urandom_range(0, 8'h1F)));
        endcase
      end
      3: begin
        send_byte({3'b110, 5'($urandom_range(0, 31))});
        send_byte(cont_byte());
      end
      4, 5: begin
        case ($urandom_range(0, 3))
          0:       cp = 16'($urandom_range(16'h4E00, 16'h9FFF));
          1:       cp = 16'($urandom_range(16'hAC00, 16'hD7AF));
          2:       cp = 16'($urandom_range(16'hFF00, 16'hFF61));
          default: cp = 16'($urandom_range(0, 16'hFFFF));
        endcase
        send_byte({4'hE, cp[15:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
      6: begin
        send_byte(8'($urandom_range(8'hF0, 8'hFF)));
        repeat (3) send_byte(cont_byte());
      end
      7, 8: send_color_seq();
      9: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_LBRK);
        send_byte(CH_ESC);
        send_byte(b);
      end
      10:      send_byte(8'($urandom_range(8'h80, 8'hBF)));
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    bit calm;
    term_event_t got;
    taken = 0;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      // long hold-off lets the block fill up and stall its input
      if (taken == 60 || taken == 260) gap = HOLD_OFF_CYCLES;
      else gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      got.kind   = event_kind_o;
      got.cp     = code_point_o;
      got.x      = pos_x_o;
      got.y      = pos_y_o;
      got.fg     = fg_rgb_o;
      got.bg     = bg_rgb_o;
      got.wide   = double_width_o;
      got.scroll = scroll_up_o;
      board.check_event(got);
      taken++;
      if (taken % 40 == 0) calm = !calm;
    end
  end

  initial begin : stimulus
    logic [7:0] directed[$];
    int unsigned start;
    board = new();
    directed = '{8'h41, 8'h7F, 8'h20, CH_CR, 8'h00, CH_LF, 8'h80, 8'hC3, 8'hA9,
                 8'hE4, 8'hB8, 8'h80, 8'hF0, CH_ESC, CH_LF, CH_CR,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, CH_ESC, 8'h78,
                 CH_ESC, CH_LBRK, 8'h31, CH_SEMI, 8'h39, 8'h37, CH_M};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) wait_drained();
      sender_calm = ph[0];
      write_cfg(CFG_SCREEN_W, PH_SCREEN_W[ph]);
      write_cfg(CFG_SCREEN_H, PH_SCREEN_H[ph]);
      // upper data bits are don't-care for the 6-bit cell registers
      write_cfg(CFG_CELL_W, {6'($urandom_range(0, 63)), PH_CELL_W[ph][5:0]});
      write_cfg(CFG_CELL_H, {6'($urandom_range(0, 63)), PH_CELL_H[ph][5:0]});
      cfg_we_i <= 1'b0;
      if (ph == 0) foreach (directed[i]) send_byte(directed[i]);
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_PER_PHASE) send_random_chunk();
    end
    wait_drained();
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
